/* sv/pwtm_pkg.sv */
package pwtm_pkg;

    // Block geometry
    localparam int VOICES      = 25;
    localparam int TABLE_DEPTH = 1024;
    localparam int FRAC_BITS   = 16;

    localparam int TABLE_AW = $clog2(TABLE_DEPTH);
    localparam int PHASE_W  = TABLE_AW + FRAC_BITS;
    localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + VOICE_W;
    localparam int DAC_W    = 12;

    // Mixing constants
    localparam int MIX_SHIFT  = 5;
    localparam int DAC_OFFSET = 2048;
    localparam int DAC_MAX    = 4095;

    // Pitch steps, stored in 16.16 form
    localparam int PITCH_COUNT = 25;
    localparam int STEP_FRAC   = 16;

    localparam logic [31:0] PITCH_STEP [PITCH_COUNT] = '{
        32'd908269,  32'd962280,  32'd1019500, 32'd1080123, 32'd1144350,
        32'd1212397, 32'd1284490, 32'd1360870, 32'd1441792, 32'd1527525,
        32'd1618357, 32'd1714592, 32'd1816543, 32'd1924561, 32'd2039001,
        32'd2160247, 32'd2288701, 32'd2424795, 32'd2568981, 32'd2721740,
        32'd2883584, 32'd3055051, 32'd3236713, 32'd3429178, 32'd3633088
    };

    typedef enum logic [0:0] {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic               capture;
        logic               load;
        logic               step;
        logic [VOICE_W-1:0] voice;
        logic               emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Per-voice phase increment in the accumulator's fixed-point format
    function automatic logic [PHASE_W-1:0] voice_step(input logic [VOICE_W-1:0] v);
        logic [31:0] s;
        s = '0;
        if (int'(v) < PITCH_COUNT) begin
            s = PITCH_STEP[int'(v)];
        end
        if (FRAC_BITS >= STEP_FRAC) begin
            s = s << (FRAC_BITS - STEP_FRAC);
        end else begin
            s = s >> (STEP_FRAC - FRAC_BITS);
        end
        return s[PHASE_W-1:0];
    endfunction

endpackage

/* sv/pwtm_ctrl.sv */
module pwtm_ctrl
    import pwtm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [VOICE_W-1:0] r_voice, n_voice;
    logic               accept;
    logic               last_voice;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign last_voice = (r_voice == VOICE_W'(VOICES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_voice <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        case (r_state)
            ST_IDLE: begin
                n_voice = '0;
                if (accept && (i_command == CMD_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_voice) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_voice = r_voice + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        o_cmd.capture = accept && (i_command == CMD_TICK);
        o_cmd.load    = accept && (i_command == CMD_LOAD);
        o_cmd.step    = (r_state == ST_SCAN);
        o_cmd.voice   = r_voice;
        o_cmd.emit    = (r_state == ST_EMIT) && i_stat.out_free;
    end

endmodule

/* sv/pwtm_dp.sv */
module pwtm_dp
    import pwtm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [VOICES-1:0]          i_key_mask,
    input  logic [TABLE_AW-1:0]        i_table_index,
    input  logic signed [SAMPLE_W-1:0] i_table_value,
    input  logic                       i_out_stall,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    output logic [DAC_W-1:0]           o_dac_value
);

    localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W + 1)'(TABLE_DEPTH) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << MIX_SHIFT) - 1);
    localparam logic signed [SUM_W-1:0] OFFSET_S   = SUM_W'(DAC_OFFSET);
    localparam logic signed [SUM_W-1:0] MAX_S      = SUM_W'(DAC_MAX);

    logic [PHASE_W-1:0]        r_phase [VOICES];
    logic [VOICES-1:0]         r_mask;
    logic [SAMPLE_W-1:0]       r_wave [TABLE_DEPTH];
    logic [SAMPLE_W-1:0]       r_rd_data;
    logic                      r_acc_en;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_out_valid;
    logic [DAC_W-1:0]          r_dac;

    logic [PHASE_W:0]          p_sum;
    logic [PHASE_W-1:0]        n_phase;
    logic [TABLE_AW-1:0]       rd_addr;
    logic                      voice_on;
    logic signed [SUM_W-1:0]   bias;
    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   biased;
    logic [DAC_W-1:0]          n_dac;

    // Phase advance with a single wrap at the table length
    always_comb begin
        voice_on = i_cmd.step && r_mask[i_cmd.voice];
        p_sum    = {1'b0, r_phase[i_cmd.voice]} + {1'b0, voice_step(i_cmd.voice)};
        if (p_sum >= PHASE_LIMIT) begin
            p_sum = p_sum - PHASE_LIMIT;
        end
        n_phase = p_sum[PHASE_W-1:0];
        rd_addr = n_phase[PHASE_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else if (voice_on) begin
            r_phase[i_cmd.voice] <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask <= i_key_mask;
        end
    end

    // Wave table: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wave[i_table_index] <= i_table_value;
        end
        r_rd_data <= r_wave[rd_addr];
    end

    // Accumulate in the cycle after the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= voice_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sum <= '0;
        end else if (r_acc_en) begin
            r_sum <= r_sum + {{(SUM_W - SAMPLE_W){r_rd_data[SAMPLE_W-1]}}, r_rd_data};
        end
    end

    // Divide toward zero, offset, clip
    always_comb begin
        bias   = r_sum[SUM_W-1] ? ROUND_BIAS : '0;
        quot   = (r_sum + bias) >>> MIX_SHIFT;
        biased = quot + OFFSET_S;
        if (biased > MAX_S) begin
            n_dac = DAC_W'(DAC_MAX);
        end else if (biased[SUM_W-1]) begin
            n_dac = '0;
        end else begin
            n_dac = biased[DAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_dac <= n_dac;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_dac_value     = r_dac;

endmodule

/* sv/polyphonic_wavetable_mixer.sv */
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_command, i_key_mask, i_table_index,
//                                               i_table_value
// out      output     o_out_valid / i_out_stall o_dac_value
//
// A load word is written into the table at the accept edge and the input stays
// open. A tick word closes the input while the sequencer visits one voice per
// cycle through the single wave table read port; then a drain state lets the last
// read be accumulated and an emit state loads the output register.
// Reset is synchronous, active low; it clears all phases and control state.
// The wave table is not cleared. A stalled output holds its word while the
// input keeps taking words; a finished tick waits only if the output is full.
module polyphonic_wavetable_mixer
    import pwtm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic [VOICES-1:0]          i_key_mask,
    input  logic [TABLE_AW-1:0]        i_table_index,
    input  logic signed [SAMPLE_W-1:0] i_table_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [DAC_W-1:0]           o_dac_value
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: accepts words, walks the voices, schedules the output load
    pwtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // Datapath: phase accumulators, wave table, mix sum and output register
    pwtm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_key_mask    (i_key_mask),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_out_stall   (i_out_stall),
        .o_stat        (dp_stat),
        .o_out_valid   (o_out_valid),
        .o_dac_value   (o_dac_value)
    );

endmodule

/* sv/pwtm_checker.sv */
module pwtm_checker
    import pwtm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_command,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DAC_W-1:0]   o_dac_value
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dac_value))
        else $error("output word changed under stall");

    // A tick closes the input while the voices are visited
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_TICK) |=> o_in_stall)
        else $error("input open right after a tick");

    // A load leaves the input open
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_LOAD) |=> !o_in_stall)
        else $error("input closed after a load");

    // A new output word only ever comes from a tick in progress
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word without a tick in progress");

endmodule

bind polyphonic_wavetable_mixer pwtm_checker u_pwtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_dac_value (o_dac_value)
);

/* dv/polyphonic_wavetable_mixer_test.sv */
module polyphonic_wavetable_mixer_test;
    import pwtm_pkg::*;

    // Two copies of the synth state: PLAN follows the words as they are queued
    // (so ticks never read a table entry that has not been written yet), LIVE
    // follows the words as the block accepts them and yields the expected DAC words.
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    localparam int RANDOM_CHUNK   = 160;             // three idling phases of this size
    localparam int HOLD_CYCLES    = 400;             // long output hold-off
    localparam int DRAIN_CYCLES   = 2 * (VOICES + 3) + 8;
    localparam int WATCHDOG_LIMIT = 4000;            // cycles with no word moving

    typedef struct {
        t_cmd                        cmd;
        logic [VOICES-1:0]           keys;
        logic [TABLE_AW-1:0]         index;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_synth_word;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       i_command     = CMD_TICK;
    logic [VOICES-1:0]          i_key_mask    = '0;
    logic [TABLE_AW-1:0]        i_table_index = '0;
    logic signed [SAMPLE_W-1:0] i_table_value = '0;
    logic                       i_out_stall   = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [DAC_W-1:0]           o_dac_value;

    t_synth_word                pending_words [$];
    logic [DAC_W-1:0]           dac_expected [$];

    longint                     phase_st [2][VOICES];
    logic signed [SAMPLE_W-1:0] wave_st [2][TABLE_DEPTH];
    bit                         wave_written [TABLE_DEPTH];

    int send_idle_pct = 30;
    int recv_idle_pct = 59;
    bit hold_armed    = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int errors        = 0;

    polyphonic_wavetable_mixer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key_mask    (i_key_mask),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dac_value   (o_dac_value)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Synth model
    // ------------------------------------------------------------------

    // Pitch increment of one voice, rescaled from 16.16 to the phase format.
    // Voices past the pitch list stand still.
    function automatic longint pitch_increment(int v);
        longint s;
        s = (v < PITCH_COUNT) ? longint'(PITCH_STEP[v]) : 0;
        if (FRAC_BITS >= STEP_FRAC) begin
            return s << (FRAC_BITS - STEP_FRAC);
        end
        return s >> (STEP_FRAC - FRAC_BITS);
    endfunction

    // Phase a voice reaches on its next tick: wrap once at the table length,
    // then reduce modulo the length if the step overshoots even after that.
    function automatic longint next_phase(int bank, int v);
        longint span;
        longint p;
        span = longint'(TABLE_DEPTH) << FRAC_BITS;
        p = phase_st[bank][v] + pitch_increment(v);
        if (p >= span) begin
            p -= span;
        end
        if (p >= span) begin
            p %= span;
        end
        return p;
    endfunction

    function automatic logic [TABLE_AW-1:0] next_entry(int bank, int v);
        return TABLE_AW'(next_phase(bank, v) >> FRAC_BITS);
    endfunction

    // Advance every pressed voice, sum its table entries, scale by 1/32
    // (toward zero), offset to mid-scale and clip to the DAC range.
    function automatic logic [DAC_W-1:0] mix_tick(int bank, logic [VOICES-1:0] keys);
        int sum;
        int mixed;
        sum = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (keys[v]) begin
                phase_st[bank][v] = next_phase(bank, v);
                sum += int'(wave_st[bank][phase_st[bank][v] >> FRAC_BITS]);
            end
        end
        mixed = sum / (1 << MIX_SHIFT) + DAC_OFFSET;
        if (mixed > DAC_MAX) begin
            mixed = DAC_MAX;
        end else if (mixed < 0) begin
            mixed = 0;
        end
        return mixed[DAC_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Word builders (PLAN side)
    // ------------------------------------------------------------------

    function automatic void queue_load(logic [TABLE_AW-1:0] index,
                                       logic signed [SAMPLE_W-1:0] sample);
        t_synth_word w;
        w.cmd    = CMD_LOAD;
        w.keys   = VOICES'($urandom);
        w.index  = index;
        w.sample = sample;
        wave_st[PLAN][index] = sample;
        wave_written[index]  = 1'b1;
        pending_words.push_back(w);
    endfunction

    // Drop any key whose next entry is still unwritten, then queue the tick.
    function automatic void queue_tick(logic [VOICES-1:0] keys);
        t_synth_word w;
        for (int v = 0; v < VOICES; v++) begin
            if (keys[v] && !wave_written[next_entry(PLAN, v)]) begin
                keys[v] = 1'b0;
            end
        end
        w.cmd    = CMD_TICK;
        w.keys   = keys;
        w.index  = TABLE_AW'($urandom);
        w.sample = SAMPLE_W'($urandom);
        void'(mix_tick(PLAN, keys));
        pending_words.push_back(w);
    endfunction

    // Write the entry that voice v reads on its next tick.
    function automatic void load_next(int v, logic signed [SAMPLE_W-1:0] sample);
        queue_load(next_entry(PLAN, v), sample);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(5))
            0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2:       return SAMPLE_W'(int'($urandom_range(64)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [VOICES-1:0] pick_keys();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2:       return VOICES'(1) << $urandom_range(VOICES - 1);
            3, 4:    return VOICES'($urandom & $urandom & $urandom);
            default: return VOICES'($urandom);
        endcase
    endfunction

    // Mostly ticks, with table rewrites mixed in.
    function automatic void queue_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                queue_load(TABLE_AW'($urandom), pick_sample());
            end else begin
                queue_tick(pick_keys());
            end
        end
    endfunction

    // Hold the sender until every queued word has gone in and every
    // expected DAC word has come out.
    task automatic wait_drained();
        while (pending_words.size() != 0 || i_in_valid || dac_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: predict on accept, then offer the next word or idle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : feed_words
        t_synth_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_command == CMD_LOAD) begin
                    wave_st[LIVE][i_table_index] = i_table_value;
                end else begin
                    dac_expected.push_back(mix_tick(LIVE, i_key_mask));
                end
            end
            // A stalled word stays put; otherwise advance or idle.
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_command     <= w.cmd;
                    i_key_mask    <= w.keys;
                    i_table_index <= w.index;
                    i_table_value <= w.sample;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each accepted DAC word, then choose the stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_dac
        logic [DAC_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (dac_expected.size() == 0) begin
                    errors++;
                    $display("%0t: dac_value expected none, got %0d", $time, o_dac_value);
                end else begin
                    want = dac_expected.pop_front();
                    if (o_dac_value !== want) begin
                        errors++;
                        $display("%0t: dac_value expected %0d, got %0d",
                                 $time, want, o_dac_value);
                    end
                end
            end
            // One long hold-off when armed, random stalls otherwise.
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (hold_armed && !hold_done) begin
                i_out_stall <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** polyphonic_wavetable_mixer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Silence: no keys gives exactly mid-scale.
        queue_tick('0);
        // Table index extremes with sample extremes.
        queue_load('0, {1'b1, {(SAMPLE_W-1){1'b0}}});
        queue_load('1, {1'b0, {(SAMPLE_W-1){1'b1}}});
        // Three voices at full positive scale: clip high.
        for (int v = 0; v < 3; v++) begin
            load_next(v, {1'b0, {(SAMPLE_W-1){1'b1}}});
        end
        queue_tick(VOICES'(7));
        // Three voices at full negative scale: clip low.
        for (int v = 0; v < 3; v++) begin
            load_next(v, {1'b1, {(SAMPLE_W-1){1'b0}}});
        end
        queue_tick(VOICES'(7));
        // Scaling truncates toward zero: -1 and +31 stay at mid-scale, -33 drops one.
        load_next(VOICES - 1, -SAMPLE_W'(1));
        queue_tick(VOICES'(1) << (VOICES - 1));
        load_next(VOICES - 1, -SAMPLE_W'(33));
        queue_tick(VOICES'(1) << (VOICES - 1));
        load_next(VOICES - 1, SAMPLE_W'(31));
        queue_tick(VOICES'(1) << (VOICES - 1));

        // Fill the whole table so random ticks may press any key.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            queue_load(TABLE_AW'(i), pick_sample());
        end

        // Phase one: sender idles lightly, receiver stalls heavily.
        queue_random(RANDOM_CHUNK);
        wait_drained();

        // Phase two: the other way round.
        send_idle_pct = 59;
        recv_idle_pct = 30;
        queue_random(RANDOM_CHUNK);
        wait_drained();

        // Phase three: no idling, opened by a long output hold-off so the
        // block backs up and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
        queue_random(RANDOM_CHUNK);
        wait_drained();

        // Let any stray word surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("** polyphonic_wavetable_mixer: PASSED **");
        end else begin
            $display("** polyphonic_wavetable_mixer: FAILED **");
        end
        $finish;
    end

endmodule
